### sv/i2c_master_byte_engine_core_defines.svh
// Assertion macros shared by the I2C byte engine RTL.
`ifndef I2C_MASTER_BYTE_ENGINE_CORE_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define I2CMB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define I2CMB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/i2cmb_pkg.sv
// Types, codes and state layout for the I2C byte engine.
package i2cmb_pkg;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_START   = 3'd1,
    CMD_STOP    = 3'd2,
    CMD_WRITE   = 3'd3,
    CMD_READ    = 3'd4,
    CMD_STRETCH = 3'd5
  } cmd_t;

  typedef enum logic [4:0] {
    PH_IDLE          = 5'd0,
    PH_START_B       = 5'd1,
    PH_START_C       = 5'd2,
    PH_STOP_B        = 5'd3,
    PH_STOP_C        = 5'd4,
    PH_STOP_D        = 5'd5,
    PH_WR_HIGH       = 5'd6,
    PH_WR_LOW        = 5'd7,
    PH_WR_ACK_RISE   = 5'd8,
    PH_WR_ACK_SAMPLE = 5'd9,
    PH_WR_ACK_END    = 5'd10,
    PH_RD_RISE       = 5'd11,
    PH_RD_SAMPLE     = 5'd12,
    PH_RD_ACK_RISE   = 5'd13,
    PH_RD_ACK_END    = 5'd14,
    PH_ST_RELEASE    = 5'd15,
    PH_ST_POLL       = 5'd16
  } phase_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NACK    = 2'd1,
    STAT_TIMEOUT = 2'd2
  } status_t;

  // register indexes on the config port
  localparam logic REG_DELAY_TICKS   = 1'b0;
  localparam logic REG_STRETCH_LIMIT = 1'b1;

  localparam logic [7:0] DELAY_TICKS_RST   = 8'd1;
  localparam logic [7:0] STRETCH_LIMIT_RST = 8'd10;
  localparam logic [7:0] CNT_MAX           = 8'hFF;
  localparam logic [3:0] BITS_PER_BYTE     = 4'd8;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] data_byte;
    logic       send_ack;
    logic       sda_in;
    logic       scl_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic [1:0] status;
    logic       rejected;
  } out_item_t;

  typedef struct packed {
    phase_t     phase;
    logic [2:0] active_command;
    logic [3:0] bit_index;
    logic [7:0] shift_byte;
    logic [7:0] delay_count;
    logic [7:0] stretch_count;
    logic       ack_choice;
    logic       scl_level;
    logic       sda_level;
    logic [1:0] last_status;
    logic [7:0] read_hold;
  } seq_state_t;

  localparam seq_state_t SEQ_STATE_RST = '{
    phase:          PH_IDLE,
    active_command: 3'd0,
    bit_index:      4'd0,
    shift_byte:     8'd0,
    delay_count:    8'd0,
    stretch_count:  8'd0,
    ack_choice:     1'b0,
    scl_level:      1'b1,
    sda_level:      1'b1,
    last_status:    2'd0,
    read_hold:      8'd0
  };

endpackage

### sv/i2cmb_seq.sv
// Line sequencer step: next state and result beat for one input item.
module i2cmb_seq
  import i2cmb_pkg::*;
(
  input  seq_state_t st,
  input  in_item_t   item,
  input  logic [7:0] delay_ticks,
  input  logic [7:0] stretch_limit,
  output seq_state_t st_nxt,
  output out_item_t  res
);

  logic       is_cmd;
  logic       done;
  logic       rej;
  logic [7:0] eff_delay;
  logic [7:0] eff_limit;
  logic [7:0] dly_inc;
  logic [7:0] str_inc;
  logic [3:0] bit_inc;

  assign is_cmd    = (item.cmd >= CMD_START) && (item.cmd <= CMD_STRETCH);
  assign eff_delay = (delay_ticks == 8'd0) ? 8'd1 : delay_ticks;
  assign eff_limit = (stretch_limit == 8'd0) ? 8'd1 : stretch_limit;
  assign dly_inc   = (st.delay_count == CNT_MAX) ? CNT_MAX : st.delay_count + 8'd1;
  assign str_inc   = (st.stretch_count == CNT_MAX) ? CNT_MAX : st.stretch_count + 8'd1;
  assign bit_inc   = st.bit_index + 4'd1;

  always_comb begin
    st_nxt = st;
    done   = 1'b0;
    rej    = 1'b0;
    if (st.phase == PH_IDLE) begin
      if (is_cmd) begin
        st_nxt.active_command = item.cmd;
        st_nxt.delay_count    = 8'd0;
        st_nxt.bit_index      = 4'd0;
        case (item.cmd)
          CMD_START: begin
            st_nxt.scl_level = 1'b1;
            st_nxt.sda_level = 1'b1;
            st_nxt.phase     = PH_START_B;
          end
          CMD_STOP: begin
            st_nxt.scl_level = 1'b0;
            st_nxt.sda_level = 1'b0;
            st_nxt.phase     = PH_STOP_B;
          end
          CMD_WRITE: begin
            st_nxt.shift_byte = item.data_byte;
            st_nxt.scl_level  = 1'b0;
            st_nxt.sda_level  = item.data_byte[7];
            st_nxt.phase      = PH_WR_HIGH;
          end
          CMD_READ: begin
            st_nxt.shift_byte = 8'd0;
            st_nxt.ack_choice = item.send_ack;
            st_nxt.sda_level  = 1'b1;
            st_nxt.phase      = PH_RD_RISE;
          end
          default: begin
            st_nxt.phase = PH_ST_RELEASE;
          end
        endcase
      end
    end else begin
      rej                = is_cmd;
      st_nxt.delay_count = dly_inc;
      if (dly_inc >= eff_delay) begin
        st_nxt.delay_count = 8'd0;
        case (st.phase)
          PH_START_B: begin
            st_nxt.sda_level = 1'b0;
            st_nxt.phase     = PH_START_C;
          end
          PH_START_C: begin
            st_nxt.scl_level   = 1'b0;
            st_nxt.phase       = PH_IDLE;
            st_nxt.last_status = STAT_OK;
            done               = 1'b1;
          end
          PH_STOP_B: begin
            st_nxt.scl_level = 1'b1;
            st_nxt.phase     = PH_STOP_C;
          end
          PH_STOP_C: begin
            st_nxt.sda_level = 1'b1;
            st_nxt.phase     = PH_STOP_D;
          end
          PH_STOP_D: begin
            st_nxt.phase       = PH_IDLE;
            // a stop that follows a write can only come from a NACK
            st_nxt.last_status = (st.active_command == CMD_WRITE) ? STAT_NACK : STAT_OK;
            done               = 1'b1;
          end
          PH_WR_HIGH: begin
            st_nxt.scl_level = 1'b1;
            st_nxt.phase     = PH_WR_LOW;
          end
          PH_WR_LOW: begin
            st_nxt.scl_level = 1'b0;
            st_nxt.bit_index = bit_inc;
            if (bit_inc < BITS_PER_BYTE) begin
              st_nxt.shift_byte = {st.shift_byte[6:0], 1'b0};
              st_nxt.sda_level  = st.shift_byte[6];
              st_nxt.phase      = PH_WR_HIGH;
            end else begin
              st_nxt.sda_level = 1'b1;
              st_nxt.phase     = PH_WR_ACK_RISE;
            end
          end
          PH_WR_ACK_RISE: begin
            st_nxt.scl_level = 1'b1;
            st_nxt.phase     = PH_WR_ACK_SAMPLE;
          end
          PH_WR_ACK_SAMPLE: begin
            if (item.sda_in) begin
              st_nxt.scl_level = 1'b0;
              st_nxt.sda_level = 1'b0;
              st_nxt.phase     = PH_STOP_B;
            end else begin
              st_nxt.phase = PH_WR_ACK_END;
            end
          end
          PH_WR_ACK_END: begin
            st_nxt.scl_level   = 1'b0;
            st_nxt.phase       = PH_IDLE;
            st_nxt.last_status = STAT_OK;
            done               = 1'b1;
          end
          PH_RD_RISE: begin
            st_nxt.scl_level = 1'b1;
            st_nxt.phase     = PH_RD_SAMPLE;
          end
          PH_RD_SAMPLE: begin
            st_nxt.shift_byte = {st.shift_byte[6:0], item.sda_in};
            st_nxt.scl_level  = 1'b0;
            st_nxt.bit_index  = bit_inc;
            if (bit_inc < BITS_PER_BYTE) begin
              st_nxt.phase = PH_RD_RISE;
            end else begin
              st_nxt.sda_level = ~st.ack_choice;
              st_nxt.phase     = PH_RD_ACK_RISE;
            end
          end
          PH_RD_ACK_RISE: begin
            st_nxt.scl_level = 1'b1;
            st_nxt.phase     = PH_RD_ACK_END;
          end
          PH_RD_ACK_END: begin
            st_nxt.scl_level   = 1'b0;
            st_nxt.read_hold   = st.shift_byte;
            st_nxt.phase       = PH_IDLE;
            st_nxt.last_status = STAT_OK;
            done               = 1'b1;
          end
          PH_ST_RELEASE: begin
            st_nxt.scl_level     = 1'b1;
            st_nxt.stretch_count = 8'd0;
            st_nxt.phase         = PH_ST_POLL;
          end
          PH_ST_POLL: begin
            if (item.scl_in) begin
              st_nxt.phase       = PH_IDLE;
              st_nxt.last_status = STAT_OK;
              done               = 1'b1;
            end else begin
              st_nxt.stretch_count = str_inc;
              if (str_inc >= eff_limit) begin
                st_nxt.phase       = PH_IDLE;
                st_nxt.last_status = STAT_TIMEOUT;
                done               = 1'b1;
              end
            end
          end
          default: begin
            st_nxt.phase = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_comb begin
    res.scl_out   = st_nxt.scl_level;
    res.sda_out   = st_nxt.sda_level;
    res.busy_res  = (st_nxt.phase != PH_IDLE);
    res.done_res  = done;
    res.read_byte = st_nxt.read_hold;
    res.status    = st_nxt.last_status;
    res.rejected  = rej;
  end

endmodule

### sv/i2c_master_byte_engine_core.sv
// Top level of the I2C master byte engine: beat registers, config port, sequencer state.
//
//  channel | direction | payload    | handshake
//  --------+-----------+------------+--------------------------
//  in_     | in        | in_item_t  | in_valid / in_stall
//  out_    | out       | out_item_t | out_valid / out_stall
//  cfg     | in/out    | 32b regs   | psel / penable / pready=1
//
// One beat per cycle sustained while out_stall is low; a taken beat goes into the input
// register, one sequencer step on it feeds the result register, and from there it shows on out_.
// The sequencer state advances once per beat, in order, so throughput is set
// only by downstream stalls. out_stall backs up through the input register
// to in_stall in the same cycle. Synchronous reset idles the sequencer with
// both lines released and loads delay_ticks=1, stretch_limit=10.
module i2c_master_byte_engine_core
  import i2cmb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

`include "i2c_master_byte_engine_core_defines.svh"

  logic       in_valid_r;
  in_item_t   in_item_r;
  logic       out_valid_r;
  out_item_t  out_data_r;
  seq_state_t state_r;
  seq_state_t state_nxt;
  out_item_t  res;
  logic [7:0] delay_ticks_r;
  logic [7:0] stretch_limit_r;
  logic       out_open;
  logic       step;
  logic       cfg_wr;

  assign out_open = !out_valid_r || !out_stall;
  assign step     = in_valid_r && out_open;
  assign in_stall = in_valid_r && !out_open;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_data;
    end
  end

  i2cmb_seq u_seq (
    .st            (state_r),
    .item          (in_item_r),
    .delay_ticks   (delay_ticks_r),
    .stretch_limit (stretch_limit_r),
    .st_nxt        (state_nxt),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SEQ_STATE_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (step) begin
        state_r <= state_nxt;
      end
      if (out_open) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= res;
    end
  end

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_ticks_r   <= DELAY_TICKS_RST;
      stretch_limit_r <= STRETCH_LIMIT_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_DELAY_TICKS:   delay_ticks_r   <= pwdata[7:0];
        REG_STRETCH_LIMIT: stretch_limit_r <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DELAY_TICKS:   prdata = {24'd0, delay_ticks_r};
      REG_STRETCH_LIMIT: prdata = {24'd0, stretch_limit_r};
      default:           prdata = 32'd0;
    endcase
  end

  `I2CMB_ASSERT_NOW(a_idle_no_count, state_r.phase == PH_IDLE, state_r.delay_count == 8'd0, "delay count left running while idle")
  `I2CMB_ASSERT_NOW(a_bit_range, 1'b1, state_r.bit_index <= BITS_PER_BYTE, "bit index past a byte")
  `I2CMB_ASSERT_NEXT(a_held_beat, in_valid_r && !out_open, in_valid_r && $stable(in_item_r), "held input beat lost")
  `I2CMB_ASSERT_NOW(a_done_not_busy, out_valid_r && out_data_r.done_res, !out_data_r.busy_res, "done beat still flagged busy")

endmodule

### verif/tb.sv
// Self-checking testbench for the I2C master byte engine: directed and random beats against a line predictor.
`timescale 1ns / 1ps

module tb;
  import i2cmb_pkg::*;

  localparam logic [2:0] CODE_SPARE_A = 3'd6;
  localparam logic [2:0] CODE_SPARE_B = 3'd7;
  localparam logic [2:0] ADDR_DELAY   = {REG_DELAY_TICKS, 2'b00};
  localparam logic [2:0] ADDR_STRETCH = {REG_STRETCH_LIMIT, 2'b00};
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PRINT_CAP   = 30;

  typedef struct packed {
    phase_t     ph;
    logic [2:0] op;
    logic [3:0] nbit;
    logic [7:0] shreg;
    logic [7:0] tick_cnt;
    logic [7:0] poll_cnt;
    logic       ack_sel;
    logic       scl_q;
    logic       sda_q;
    logic [1:0] stat;
    logic [7:0] rd_byte;
  } line_seq_t;

  localparam line_seq_t LINE_SEQ_RST = '{ph: PH_IDLE, op: 3'd0, nbit: 4'd0, shreg: 8'd0,
                                         tick_cnt: 8'd0, poll_cnt: 8'd0, ack_sel: 1'b0,
                                         scl_q: 1'b1, sda_q: 1'b1, stat: 2'd0,
                                         rd_byte: 8'd0};

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  in_item_t  beat_q[$];
  out_item_t bus_levels_q[$];
  line_seq_t gen_st;
  line_seq_t pred_st;
  logic [7:0] cfg_dly;
  logic [7:0] cfg_slim;
  logic       scl_stuck;
  int n_sent;
  int n_checked;
  int err_cnt;
  int cyc;
  int in_gap;
  int calm_in;
  int stall_gap;
  int calm_out;
  int hold_left;
  logic pressed;

  i2c_master_byte_engine_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // One beat through the line sequencer; returns the levels and flags after it.
  function automatic out_item_t bus_seq_step(inout line_seq_t s, input in_item_t it,
                                             input logic [7:0] dly, input logic [7:0] slim);
    logic       is_op;
    logic       fin;
    logic       rej;
    logic [7:0] eff;
    logic [7:0] lim;
    out_item_t  r;
    fin = 1'b0;
    rej = 1'b0;
    is_op = (it.cmd >= CMD_START) && (it.cmd <= CMD_STRETCH);
    if (s.ph == PH_IDLE) begin
      if (is_op) begin
        s.op = it.cmd;
        s.tick_cnt = 8'd0;
        s.nbit = 4'd0;
        case (it.cmd)
          CMD_START: begin
            s.scl_q = 1'b1;
            s.sda_q = 1'b1;
            s.ph = PH_START_B;
          end
          CMD_STOP: begin
            s.scl_q = 1'b0;
            s.sda_q = 1'b0;
            s.ph = PH_STOP_B;
          end
          CMD_WRITE: begin
            s.shreg = it.data_byte;
            s.scl_q = 1'b0;
            s.sda_q = it.data_byte[7];
            s.ph = PH_WR_HIGH;
          end
          CMD_READ: begin
            s.shreg = 8'd0;
            s.ack_sel = it.send_ack;
            s.sda_q = 1'b1;
            s.ph = PH_RD_RISE;
          end
          default: s.ph = PH_ST_RELEASE;
        endcase
      end
    end else begin
      eff = (dly == 8'd0) ? 8'd1 : dly;
      rej = is_op;
      if (s.tick_cnt != CNT_MAX) s.tick_cnt = s.tick_cnt + 8'd1;
      if (s.tick_cnt >= eff) begin
        s.tick_cnt = 8'd0;
        case (s.ph)
          PH_START_B: begin
            s.sda_q = 1'b0;
            s.ph = PH_START_C;
          end
          PH_START_C: begin
            s.scl_q = 1'b0;
            s.ph = PH_IDLE;
            s.stat = STAT_OK;
            fin = 1'b1;
          end
          PH_STOP_B: begin
            s.scl_q = 1'b1;
            s.ph = PH_STOP_C;
          end
          PH_STOP_C: begin
            s.sda_q = 1'b1;
            s.ph = PH_STOP_D;
          end
          PH_STOP_D: begin
            s.ph = PH_IDLE;
            s.stat = (s.op == CMD_WRITE) ? STAT_NACK : STAT_OK;
            fin = 1'b1;
          end
          PH_WR_HIGH: begin
            s.scl_q = 1'b1;
            s.ph = PH_WR_LOW;
          end
          PH_WR_LOW: begin
            s.scl_q = 1'b0;
            s.nbit = s.nbit + 4'd1;
            if (s.nbit < BITS_PER_BYTE) begin
              s.shreg = s.shreg << 1;
              s.sda_q = s.shreg[7];
              s.ph = PH_WR_HIGH;
            end else begin
              s.sda_q = 1'b1;
              s.ph = PH_WR_ACK_RISE;
            end
          end
          PH_WR_ACK_RISE: begin
            s.scl_q = 1'b1;
            s.ph = PH_WR_ACK_SAMPLE;
          end
          PH_WR_ACK_SAMPLE: begin
            // NACK from the target: fall into the stop sequence
            if (it.sda_in) begin
              s.scl_q = 1'b0;
              s.sda_q = 1'b0;
              s.ph = PH_STOP_B;
            end else begin
              s.ph = PH_WR_ACK_END;
            end
          end
          PH_WR_ACK_END: begin
            s.scl_q = 1'b0;
            s.ph = PH_IDLE;
            s.stat = STAT_OK;
            fin = 1'b1;
          end
          PH_RD_RISE: begin
            s.scl_q = 1'b1;
            s.ph = PH_RD_SAMPLE;
          end
          PH_RD_SAMPLE: begin
            s.shreg = {s.shreg[6:0], it.sda_in};
            s.scl_q = 1'b0;
            s.nbit = s.nbit + 4'd1;
            if (s.nbit < BITS_PER_BYTE) begin
              s.ph = PH_RD_RISE;
            end else begin
              s.sda_q = ~s.ack_sel;
              s.ph = PH_RD_ACK_RISE;
            end
          end
          PH_RD_ACK_RISE: begin
            s.scl_q = 1'b1;
            s.ph = PH_RD_ACK_END;
          end
          PH_RD_ACK_END: begin
            s.scl_q = 1'b0;
            s.rd_byte = s.shreg;
            s.ph = PH_IDLE;
            s.stat = STAT_OK;
            fin = 1'b1;
          end
          PH_ST_RELEASE: begin
            s.scl_q = 1'b1;
            s.poll_cnt = 8'd0;
            s.ph = PH_ST_POLL;
          end
          PH_ST_POLL: begin
            if (it.scl_in) begin
              s.ph = PH_IDLE;
              s.stat = STAT_OK;
              fin = 1'b1;
            end else begin
              lim = (slim == 8'd0) ? 8'd1 : slim;
              if (s.poll_cnt != CNT_MAX) s.poll_cnt = s.poll_cnt + 8'd1;
              if (s.poll_cnt >= lim) begin
                s.ph = PH_IDLE;
                s.stat = STAT_TIMEOUT;
                fin = 1'b1;
              end
            end
          end
          default: s.ph = PH_IDLE;
        endcase
      end
    end
    r.scl_out   = s.scl_q;
    r.sda_out   = s.sda_q;
    r.busy_res  = (s.ph != PH_IDLE);
    r.done_res  = fin;
    r.read_byte = s.rd_byte;
    r.status    = s.stat;
    r.rejected  = rej;
    return r;
  endfunction

  // mostly back to back, some short gaps, rare long ones, and calm stretches
  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 63) == 0) begin
      calm = $urandom_range(40, 150);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic note_mismatch(input string fld, input logic [7:0] got, input logic [7:0] want);
    if (err_cnt < PRINT_CAP)
      $display("[%0t] beat %0d %s: got %h want %h", $time, n_checked, fld, got, want);
    err_cnt++;
  endtask

  task automatic queue_beat(input logic [2:0] c, input logic [7:0] d, input logic a,
                            input logic sda, input logic scl);
    in_item_t  it;
    it.cmd = c;
    it.data_byte = d;
    it.send_ack = a;
    it.sda_in = sda;
    it.scl_in = scl;
    void'(bus_seq_step(gen_st, it, cfg_dly, cfg_slim));
    beat_q.push_back(it);
    n_sent++;
  endtask

  // command followed by ticks at fixed line levels until it completes;
  // poke drops a busy command and a spare code into the first ticks
  task automatic queue_command(input logic [2:0] c, input logic [7:0] d, input logic a,
                               input logic sda, input logic scl, input logic poke);
    int n;
    logic [2:0] t;
    n = 0;
    queue_beat(c, d, a, sda, scl);
    while (gen_st.ph != PH_IDLE) begin
      t = CMD_TICK;
      if (poke && n == 0) t = CMD_STOP;
      if (poke && n == 1) t = CODE_SPARE_B;
      queue_beat(t, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), sda, scl);
      n++;
    end
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [7:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {24'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_DELAY) cfg_dly = val;
    else cfg_slim = val;
  endtask

  task automatic drain();
    while (n_checked < n_sent) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic run_phase(input logic [7:0] dly, input logic [7:0] slim, input int budget);
    int k;
    logic busy;
    logic [2:0] c;
    logic scl;
    cfg_write(ADDR_DELAY, dly);
    cfg_write(ADDR_STRETCH, slim);
    k = 0;
    while (k < budget) begin
      busy = (gen_st.ph != PH_IDLE);
      if (!busy) begin
        if ($urandom_range(0, 19) < 2) begin
          case ($urandom_range(0, 2))
            0: c = CMD_TICK;
            1: c = CODE_SPARE_A;
            default: c = CODE_SPARE_B;
          endcase
        end else begin
          c = 3'($urandom_range(CMD_START, CMD_STRETCH));
          if (c == CMD_STRETCH) scl_stuck = ($urandom_range(0, 2) == 0);
        end
      end else begin
        c = ($urandom_range(0, 99) < 12) ? 3'($urandom_range(CMD_START, CODE_SPARE_B))
                                         : CMD_TICK;
      end
      scl = scl_stuck ? 1'b0 : ($urandom_range(0, 3) == 0);
      queue_beat(c, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), scl);
      if (busy || (c >= CMD_START && c <= CMD_STRETCH)) k++;
    end
    drain();
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (beat_q.size() != 0) begin
        in_data  <= beat_q.pop_front();
        in_valid <= 1'b1;
        in_gap   <= idle_len(calm_in);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off so the block backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_gap <= 0;
      hold_left <= 0;
      pressed   <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!pressed && n_checked >= 400 && beat_q.size() > 20) begin
      pressed   <= 1'b1;
      out_stall <= 1'b1;
      hold_left <= 300;
    end else if (stall_gap != 0) begin
      out_stall <= 1'b1;
      stall_gap <= stall_gap - 1;
    end else begin
      out_stall <= 1'b0;
      stall_gap <= idle_len(calm_out);
    end
  end

  // monitor: predict on accepted input beats, compare accepted output beats
  always @(posedge clk) begin : mon
    out_item_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        want = bus_seq_step(pred_st, in_data, cfg_dly, cfg_slim);
        bus_levels_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (bus_levels_q.size() == 0) begin
          note_mismatch("beat with nothing expected", 8'd0, 8'd0);
        end else begin
          want = bus_levels_q.pop_front();
          if (out_data.scl_out !== want.scl_out)
            note_mismatch("scl_out", 8'(out_data.scl_out), 8'(want.scl_out));
          if (out_data.sda_out !== want.sda_out)
            note_mismatch("sda_out", 8'(out_data.sda_out), 8'(want.sda_out));
          if (out_data.busy_res !== want.busy_res)
            note_mismatch("busy_res", 8'(out_data.busy_res), 8'(want.busy_res));
          if (out_data.done_res !== want.done_res)
            note_mismatch("done_res", 8'(out_data.done_res), 8'(want.done_res));
          if (out_data.read_byte !== want.read_byte)
            note_mismatch("read_byte", out_data.read_byte, want.read_byte);
          if (out_data.status !== want.status)
            note_mismatch("status", 8'(out_data.status), 8'(want.status));
          if (out_data.rejected !== want.rejected)
            note_mismatch("rejected", 8'(out_data.rejected), 8'(want.rejected));
        end
        n_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("i2c_master_byte_engine_core: mismatch");
      $finish;
    end
  end

  initial begin
    clk       = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    cyc       = 0;
    n_sent    = 0;
    n_checked = 0;
    err_cnt   = 0;
    calm_in   = 0;
    calm_out  = 0;
    scl_stuck = 1'b0;
    gen_st    = LINE_SEQ_RST;
    pred_st   = LINE_SEQ_RST;
    cfg_dly   = DELAY_TICKS_RST;
    cfg_slim  = STRETCH_LIMIT_RST;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle noise, each command, ACK/NACK both ways, stretch ok and timeout
    queue_beat(CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b0);
    queue_beat(CODE_SPARE_A, 8'hFF, 1'b1, 1'b1, 1'b1);
    queue_beat(CODE_SPARE_B, 8'h00, 1'b0, 1'b0, 1'b0);
    queue_command(CMD_STOP, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
    queue_command(CMD_START, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
    queue_command(CMD_WRITE, 8'hFF, 1'b0, 1'b0, 1'b1, 1'b0);
    queue_command(CMD_WRITE, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1);
    queue_command(CMD_READ, 8'hA5, 1'b1, 1'b1, 1'b1, 1'b0);
    queue_command(CMD_READ, 8'h5A, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_command(CMD_STRETCH, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
    queue_command(CMD_STRETCH, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0);
    drain();

    run_phase(8'd2, 8'd3, 280);
    run_phase(8'd0, 8'd0, 280);
    run_phase(8'd1, 8'd255, 420);
    run_phase(8'd255, 8'd1, 520);
    run_phase(8'd1, 8'd1, 250);
    run_phase(8'd5, 8'd200, 200);

    if (bus_levels_q.size() != 0) note_mismatch("results missing", 8'd0, 8'd0);
    if (err_cnt == 0) begin
      $display("i2c_master_byte_engine_core: match");
    end else begin
      $display("i2c_master_byte_engine_core: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/i2cmb_pkg.sv
sv/i2cmb_seq.sv
sv/i2c_master_byte_engine_core.sv
verif/tb.sv
